// ----- hw/rtl/bsec_pkg.sv -----
// Package for the byte stuffing escape codec: request types, escape byte
// constants and the per-request step result type. No dependencies.
package bsec_pkg;

  localparam logic [7:0] ByteFf = 8'hFF;
  localparam logic [7:0] ByteFe = 8'hFE;
  localparam logic [7:0] ByteFd = 8'hFD;
  localparam logic [7:0] ByteFc = 8'hFC;

  typedef enum logic {
    ModeEscape   = 1'b0,
    ModeUnescape = 1'b1
  } mode_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_req_t;

  // Outcome of one input request: up to two output bytes and the new
  // pending-escape bit.
  typedef struct packed {
    logic [1:0] cnt;
    out_req_t   res0;
    out_req_t   res1;
    logic       pend;
  } step_t;

endpackage

// ----- hw/rtl/bsec_step.sv -----
// Combinational step of the codec: maps one input request and the
// pending-escape bit to up to two output bytes. Depends on bsec_pkg.
module bsec_step import bsec_pkg::*; (
  input  in_req_t req_i,
  input  logic    pend_i,
  output step_t   step_o
);

  logic [7:0] b;
  logic       l;

  assign b = req_i.data_byte;
  assign l = req_i.last;

  always_comb begin
    step_o      = '0;
    step_o.res0 = '{out_byte: b, out_last: l};
    step_o.res1 = '{out_byte: b, out_last: l};
    if (mode_e'(req_i.mode) == ModeEscape) begin
      step_o.pend = 1'b0;
      if (b == ByteFf) begin
        step_o.cnt  = 2'd2;
        step_o.res0 = '{out_byte: ByteFe, out_last: 1'b0};
        step_o.res1 = '{out_byte: ByteFd, out_last: l};
      end else if (b == ByteFe) begin
        step_o.cnt  = 2'd2;
        step_o.res0 = '{out_byte: ByteFe, out_last: 1'b0};
        step_o.res1 = '{out_byte: ByteFc, out_last: l};
      end else begin
        step_o.cnt = 2'd1;
      end
    end else if (!pend_i) begin
      if (b == ByteFe && !l) begin
        step_o.cnt  = 2'd0;
        step_o.pend = 1'b1;
      end else begin
        step_o.cnt = 2'd1;
      end
    end else if (b == ByteFd) begin
      step_o.cnt  = 2'd1;
      step_o.res0 = '{out_byte: ByteFf, out_last: l};
    end else if (b == ByteFc) begin
      step_o.cnt  = 2'd1;
      step_o.res0 = '{out_byte: ByteFe, out_last: l};
    end else begin
      // held 0xFE goes out literally, current byte treated as fresh
      step_o.res0 = '{out_byte: ByteFe, out_last: 1'b0};
      if (b == ByteFe && !l) begin
        step_o.cnt  = 2'd1;
        step_o.pend = 1'b1;
      end else begin
        step_o.cnt = 2'd2;
      end
    end
  end

endmodule

// ----- hw/rtl/byte_stuffing_escape_codec_core.sv -----
// Byte stuffing escape codec, top level: input register, step logic,
// two-byte result register. Depends on bsec_pkg and bsec_step.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_req_i carries one byte with
//   a mode bit (0 escape, 1 unescape) and a last-of-buffer flag. Output
//   channel out_valid_o / out_stall_i / out_req_o carries one produced byte
//   and its last flag. A request is taken when valid is high and stall low.
//   The first output byte of a request passes from the input register
//   through the step logic into the result register, which it enters
//   when the result register is free or releases its last byte.
//   One input request per cycle is taken while each yields at most one
//   byte and the receiver does not stall; a request that yields two bytes
//   holds the result register until both have left the single output port.
//   A 0xFE held in unescape mode yields nothing until the next byte.
//   Reset clears the valid flags and the pending-escape bit.
//   When the receiver stalls, the result register holds its byte and the
//   input register fills; in_stall_o then rises until the output drains.
module byte_stuffing_escape_codec_core import bsec_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  logic     in_valid_q;
  in_req_t  in_q;
  logic     pend_q, pend_d;
  logic     res_valid_q, res_valid_d;
  logic     res_two_q;
  logic     idx_q, idx_d;
  out_req_t res0_q, res1_q;
  step_t    step;
  logic     res_done, move, in_take;

  bsec_step u_step (
    .req_i  (in_q),
    .pend_i (pend_q),
    .step_o (step)
  );

  assign res_done   = res_valid_q && !out_stall_i && (idx_q == res_two_q);
  assign move       = in_valid_q && (!res_valid_q || res_done);
  assign in_stall_o = in_valid_q && !move;
  assign in_take    = in_valid_i && !in_stall_o;

  assign out_valid_o = res_valid_q;
  assign out_req_o   = idx_q ? res1_q : res0_q;

  always_comb begin
    pend_d      = pend_q;
    res_valid_d = res_valid_q;
    idx_d       = idx_q;
    if (res_valid_q && !out_stall_i) begin
      if (res_done) begin
        res_valid_d = 1'b0;
        idx_d       = 1'b0;
      end else begin
        idx_d = 1'b1;
      end
    end
    if (move) begin
      pend_d      = step.pend;
      res_valid_d = (step.cnt != 2'd0);
      idx_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (move) begin
        in_valid_q <= 1'b0;
      end
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_req_i;
    end
    if (move) begin
      res0_q    <= step.res0;
      res1_q    <= step.res1;
      res_two_q <= (step.cnt == 2'd2);
    end
  end

endmodule

// ----- hw/rtl/bsec_checker.sv -----
// Port-level checks for the byte stuffing escape codec top level, attached
// by the bind below. Depends on bsec_pkg.
module bsec_checker import bsec_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_req_t out_req_o
);

  // stalled output request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled output request changed");

  // input backs up only behind a full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  // nothing comes out straight after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("output busy after reset");

  // a valid output request is fully known
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(out_req_o))
    else $error("unknown bits in valid output request");

endmodule

bind byte_stuffing_escape_codec_core bsec_checker u_bsec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);
